/* sv/assert_macros.svh */
// Assertion macros shared by the checker files of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// When the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

/* sv/tfe_pkg.sv */
// Shared constants and types of the telemetry frame encoder.
// Used by the merge and serializer modules, the top level, the checker and the testbench.
package tfe_pkg;

    localparam int NUM_LANES = 9;
    localparam int RAW_LANE  = 6;

    localparam logic [7:0] HDR0         = 8'hA5;
    localparam logic [7:0] HDR1         = 8'h5A;
    localparam logic [7:0] TAIL         = 8'hAA;
    localparam logic [7:0] ATT_ID       = 8'hA1;
    localparam logic [7:0] MOT_ID       = 8'hA2;
    localparam logic [7:0] ATT_LEN_CODE = 8'h12;
    localparam logic [7:0] MOT_LEN_CODE = 8'h16;
    localparam logic [7:0] ATT_SEED     = 8'hB3;
    localparam logic [7:0] MOT_SEED     = 8'hB8;

    // Frame lengths in bytes.
    localparam logic [4:0] ATT_LEN = 5'd20;
    localparam logic [4:0] MOT_LEN = 5'd24;

    localparam logic MODE_ATT = 1'b0;
    localparam logic MODE_MOT = 1'b1;

    typedef logic [NUM_LANES-1:0][15:0] t_words;
    typedef logic [NUM_LANES-1:0][7:0]  t_sums;

    // One fully prepared frame, handed from the merge stage to the serializer.
    typedef struct packed {
        logic       mode;
        t_words     words;
        logic [7:0] chk;
    } t_frame;

endpackage

/* sv/telemetry_frame_encoder_top.sv */
// Top level of the telemetry frame encoder: input stage, sample lanes, checksum
// merge and byte serializer. Depends on tfe_pkg, tfe_lane, tfe_merge, tfe_serializer.
//
// The block takes one item (a mode bit and nine signed 16-bit samples) per
// input transfer and sends one telemetry frame as a stream of byte transfers,
// with o_last_byte high on the closing 0xAA byte. An attitude frame (mode 0)
// is 20 bytes, a motion frame (mode 1) is 24 bytes. The byte serializer sends
// one byte per cycle while the receiver is ready. Nine lanes convert the
// samples to sign-magnitude form, the attitude rate sample excepted, and form
// their byte sums in the cycle of the input transfer; the results sit in an
// input holding register while the previous frame is still being sent, and
// the merge stage forms the checksum as the frame moves into the serializer.
// With an idle block an item passes the holding register and the serializer
// register before its first byte appears, and frames follow each other on the
// output without a gap if the next item arrives within the current frame's time.
module telemetry_frame_encoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_mode,
    input  logic signed [15:0] i_sample_0,
    input  logic signed [15:0] i_sample_1,
    input  logic signed [15:0] i_sample_2,
    input  logic signed [15:0] i_sample_3,
    input  logic signed [15:0] i_sample_4,
    input  logic signed [15:0] i_sample_5,
    input  logic signed [15:0] i_sample_6,
    input  logic signed [15:0] i_sample_7,
    input  logic signed [15:0] i_sample_8,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_frame_byte,
    output logic               o_last_byte
);

    logic [tfe_pkg::NUM_LANES-1:0][15:0] w_samples;
    tfe_pkg::t_words w_words;
    tfe_pkg::t_sums  w_sums;

    // Input holding register: lane results of the item waiting for the serializer.
    tfe_pkg::t_words r_words;
    tfe_pkg::t_words n_words;
    tfe_pkg::t_sums  r_sums;
    tfe_pkg::t_sums  n_sums;
    logic            r_mode;
    logic            n_mode;
    logic            r_hold;
    logic            n_hold;

    logic            w_accept;
    logic            w_load;
    logic [7:0]      w_chk;
    tfe_pkg::t_frame w_frame;

    assign w_samples[0] = $unsigned(i_sample_0);
    assign w_samples[1] = $unsigned(i_sample_1);
    assign w_samples[2] = $unsigned(i_sample_2);
    assign w_samples[3] = $unsigned(i_sample_3);
    assign w_samples[4] = $unsigned(i_sample_4);
    assign w_samples[5] = $unsigned(i_sample_5);
    assign w_samples[6] = $unsigned(i_sample_6);
    assign w_samples[7] = $unsigned(i_sample_7);
    assign w_samples[8] = $unsigned(i_sample_8);

    // The rate sample of the attitude frame is sent as its raw bit pattern.
    genvar g;
    generate
        for (g = 0; g < tfe_pkg::NUM_LANES; g++) begin : g_lane
            tfe_lane u_lane (
                .i_sample (w_samples[g]),
                .i_raw    ((g == tfe_pkg::RAW_LANE) && (i_mode == tfe_pkg::MODE_ATT)),
                .o_word   (w_words[g]),
                .o_bsum   (w_sums[g])
            );
        end
    endgenerate

    // The holding register takes a new item only when it is empty, so the
    // input ready comes from a register, not combinationally from the output side.
    assign o_in_ready = !r_hold;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_words = r_words;
        n_sums  = r_sums;
        n_mode  = r_mode;
        n_hold  = r_hold;
        if (w_accept) begin
            n_words = w_words;
            n_sums  = w_sums;
            n_mode  = i_mode;
            n_hold  = 1'b1;
        end else if (w_load) begin
            n_hold = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else begin
            r_hold <= n_hold;
        end
        r_words <= n_words;
        r_sums  <= n_sums;
        r_mode  <= n_mode;
    end

    tfe_merge u_merge (
        .i_mode (r_mode),
        .i_sums (r_sums),
        .o_chk  (w_chk)
    );

    assign w_frame.mode  = r_mode;
    assign w_frame.words = r_words;
    assign w_frame.chk   = w_chk;

    tfe_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_hold),
        .i_frame      (w_frame),
        .o_load       (w_load),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_byte       (o_frame_byte),
        .o_last       (o_last_byte)
    );

endmodule

/* sv/tfe_lane.sv */
// One sample lane: sign-magnitude conversion and byte sum of one 16-bit sample.
// Depends on nothing outside this file.
module tfe_lane (
    input  logic [15:0] i_sample,
    input  logic        i_raw,
    output logic [15:0] o_word,
    output logic [7:0]  o_bsum
);

    logic [15:0] w_neg;

    // A negative value becomes 0x8000 plus its magnitude, kept to 16 bits.
    assign w_neg  = 16'h8000 + (~i_sample + 16'd1);
    assign o_word = (i_raw || !i_sample[15]) ? i_sample : w_neg;
    assign o_bsum = o_word[15:8] + o_word[7:0];

endmodule

/* sv/tfe_merge.sv */
// Merge stage: folds the lane byte sums and the mode's seed into the checksum.
// Depends on tfe_pkg for the seeds and the lane types.
module tfe_merge (
    input  logic           i_mode,
    input  tfe_pkg::t_sums i_sums,
    output logic [7:0]     o_chk
);

    logic [7:0] w_seed;
    logic [7:0] w_s7;
    logic [7:0] w_s8;
    logic [7:0] w_a;
    logic [7:0] w_b;
    logic [7:0] w_c;
    logic [7:0] w_d;
    logic [7:0] w_e;

    // The attitude frame carries only the first seven lanes.
    assign w_seed = (i_mode == tfe_pkg::MODE_MOT) ? tfe_pkg::MOT_SEED : tfe_pkg::ATT_SEED;
    assign w_s7   = (i_mode == tfe_pkg::MODE_MOT) ? i_sums[7] : 8'd0;
    assign w_s8   = (i_mode == tfe_pkg::MODE_MOT) ? i_sums[8] : 8'd0;

    assign w_a   = i_sums[0] + i_sums[1];
    assign w_b   = i_sums[2] + i_sums[3];
    assign w_c   = i_sums[4] + i_sums[5];
    assign w_d   = i_sums[6] + w_s7;
    assign w_e   = w_s8 + w_seed;
    assign o_chk = (w_a + w_b) + (w_c + w_d) + w_e;

endmodule

/* sv/tfe_serializer.sv */
// Byte serializer: holds one prepared frame and sends it one byte per transfer.
// Depends on tfe_pkg for the frame type, header bytes and frame lengths.
module tfe_serializer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load_valid,
    input  tfe_pkg::t_frame i_frame,
    output logic            o_load,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_byte,
    output logic            o_last
);

    tfe_pkg::t_frame r_frame;
    tfe_pkg::t_frame n_frame;
    logic            r_valid;
    logic            n_valid;
    logic [4:0]      r_idx;
    logic [4:0]      n_idx;
    logic [4:0]      w_len;
    logic [4:0]      w_k;
    logic [3:0]      w_lane;
    logic [15:0]     w_word;
    logic            w_xfer;

    assign w_len  = (r_frame.mode == tfe_pkg::MODE_MOT) ? tfe_pkg::MOT_LEN : tfe_pkg::ATT_LEN;
    assign o_last = (r_idx == w_len - 5'd1);
    assign w_xfer = r_valid && i_ready;
    assign o_load = i_load_valid && (!r_valid || (w_xfer && o_last));
    assign o_valid = r_valid;

    assign w_k    = r_idx - 5'd4;
    assign w_lane = w_k[4:1];
    assign w_word = (w_lane < 4'(tfe_pkg::NUM_LANES)) ? r_frame.words[w_lane] : 16'd0;

    always_comb begin
        priority if (r_idx == 5'd0) begin
            o_byte = tfe_pkg::HDR0;
        end else if (r_idx == 5'd1) begin
            o_byte = tfe_pkg::HDR1;
        end else if (r_idx == 5'd2) begin
            o_byte = (r_frame.mode == tfe_pkg::MODE_MOT) ? tfe_pkg::MOT_LEN_CODE
                                                           : tfe_pkg::ATT_LEN_CODE;
        end else if (r_idx == 5'd3) begin
            o_byte = (r_frame.mode == tfe_pkg::MODE_MOT) ? tfe_pkg::MOT_ID : tfe_pkg::ATT_ID;
        end else if (r_idx < w_len - 5'd2) begin
            o_byte = w_k[0] ? w_word[7:0] : w_word[15:8];
        end else if (r_idx == w_len - 5'd2) begin
            o_byte = r_frame.chk;
        end else begin
            o_byte = tfe_pkg::TAIL;
        end
    end

    always_comb begin
        n_frame = r_frame;
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_load) begin
            n_frame = i_frame;
            n_valid = 1'b1;
            n_idx   = 5'd0;
        end else if (w_xfer) begin
            if (o_last) begin
                n_valid = 1'b0;
            end
            n_idx = r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 5'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        r_frame <= n_frame;
    end

endmodule

/* sv/tfe_checker.sv */
// Port-level checker of the telemetry frame encoder, attached by a bind.
// Depends on assert_macros.svh, tfe_pkg and the ports of telemetry_frame_encoder_top.
`include "assert_macros.svh"

module tfe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_frame_byte,
    input logic       o_last_byte
);

    logic       r_first;
    logic       w_out_xfer;
    logic       w_out_stall;
    logic       w_out_tail;
    logic       w_out_first;
    logic [8:0] w_out_word;

    assign w_out_xfer  = o_out_valid && i_out_ready;
    assign w_out_stall = o_out_valid && !i_out_ready;
    assign w_out_tail  = o_out_valid && o_last_byte;
    assign w_out_first = o_out_valid && r_first;
    assign w_out_word  = {o_frame_byte, o_last_byte};

    // Marks that the next output byte opens a frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (w_out_xfer) begin
            r_first <= o_last_byte;
        end
    end

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_out_valid && $stable(w_out_word))
    `ASSERT_SAME(a_tail_byte, i_clk, i_rst_n, w_out_tail, o_frame_byte == tfe_pkg::TAIL)
    `ASSERT_SAME(a_first_hdr, i_clk, i_rst_n, w_out_first, o_frame_byte == tfe_pkg::HDR0 && !o_last_byte)
    `ASSERT_NEXT(a_hold_full, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

endmodule

bind telemetry_frame_encoder_top tfe_checker u_tfe_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_frame_byte (o_frame_byte),
    .o_last_byte  (o_last_byte)
);

/* test/telemetry_frame_encoder_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for telemetry_frame_encoder_top: directed and random frames.
// Depends on tfe_pkg and the encoder RTL; predicts every frame byte on its own.

module telemetry_frame_encoder_top_tb;

    // The run is stopped here if the block hangs. A correct run needs roughly
    // 130 frames of at most 24 bytes under heavy stalling, well below this.
    localparam int CYCLE_LIMIT  = 200000;
    // Cycles to keep watching the output once every predicted byte has come.
    localparam int DRAIN_CYCLES = 60;
    // Length of the receiver hold-off that fills the block and stalls its input.
    localparam int HOLD_OFF_LEN = 400;
    localparam int MAX_REPORTS  = 10;

    // One input item: the frame mode and the nine raw sample words.
    typedef struct packed {
        logic            mode;
        tfe_pkg::t_words smp;
    } t_frame_item;

    // One predicted output transfer.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_frame_byte;

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_mode     = tfe_pkg::MODE_ATT;
    logic signed [15:0] i_sample_0 = '0;
    logic signed [15:0] i_sample_1 = '0;
    logic signed [15:0] i_sample_2 = '0;
    logic signed [15:0] i_sample_3 = '0;
    logic signed [15:0] i_sample_4 = '0;
    logic signed [15:0] i_sample_5 = '0;
    logic signed [15:0] i_sample_6 = '0;
    logic signed [15:0] i_sample_7 = '0;
    logic signed [15:0] i_sample_8 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_frame_byte;
    logic               o_last_byte;

    // Bytes still owed by the block, oldest first, in send order.
    t_frame_byte pending_frame_bytes[$];

    // Idling controls: percent of cycles in which the sender holds back and
    // in which the receiver refuses a byte. hold_off_left is loaded by the
    // back-pressure test and counted down by the receiver process.
    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_off_left = 0;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int items_sent     = 0;
    int att_frames     = 0;
    int mot_frames     = 0;
    int bytes_checked  = 0;
    int frames_checked = 0;
    int byte_in_frame  = 0;

    telemetry_frame_encoder_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_mode       (i_mode),
        .i_sample_0   (i_sample_0),
        .i_sample_1   (i_sample_1),
        .i_sample_2   (i_sample_2),
        .i_sample_3   (i_sample_3),
        .i_sample_4   (i_sample_4),
        .i_sample_5   (i_sample_5),
        .i_sample_6   (i_sample_6),
        .i_sample_7   (i_sample_7),
        .i_sample_8   (i_sample_8),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_frame_byte (o_frame_byte),
        .o_last_byte  (o_last_byte)
    );

    // 20 ns clock period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog. A hung handshake ends the run here as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d bytes still pending.",
                     cycle_count, pending_frame_bytes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Frame prediction
    // ------------------------------------------------------------------

    // Sign-magnitude form of a two's-complement word. The sum is kept to
    // 16 bits, so the most negative value wraps around to zero.
    function automatic logic [15:0] sign_magnitude(input logic [15:0] v);
        if (v[15]) begin
            return 16'h8000 + (~v + 16'd1);
        end
        return v;
    endfunction

    function automatic void owe_byte(input logic [7:0] b, input logic last);
        t_frame_byte fb;
        fb.frame_byte = b;
        fb.last_byte  = last;
        pending_frame_bytes.push_back(fb);
    endfunction

    // Appends the full frame for one accepted item to the pending queue.
    // Attitude frames carry seven words, the seventh being the raw rate
    // word; motion frames carry all nine words in sign-magnitude form.
    function automatic void predict_frame(input t_frame_item it);
        logic        motion  = (it.mode == tfe_pkg::MODE_MOT);
        int          n_words = motion ? 9 : 7;
        logic [7:0]  csum    = motion ? tfe_pkg::MOT_SEED : tfe_pkg::ATT_SEED;
        logic [15:0] w;
        owe_byte(tfe_pkg::HDR0, 1'b0);
        owe_byte(tfe_pkg::HDR1, 1'b0);
        owe_byte(motion ? tfe_pkg::MOT_LEN_CODE : tfe_pkg::ATT_LEN_CODE, 1'b0);
        owe_byte(motion ? tfe_pkg::MOT_ID : tfe_pkg::ATT_ID, 1'b0);
        for (int i = 0; i < n_words; i++) begin
            if (!motion && i == tfe_pkg::RAW_LANE) begin
                w = it.smp[i];
            end else begin
                w = sign_magnitude(it.smp[i]);
            end
            owe_byte(w[15:8], 1'b0);
            owe_byte(w[7:0], 1'b0);
            csum = csum + w[15:8] + w[7:0];
        end
        owe_byte(csum, 1'b0);
        owe_byte(tfe_pkg::TAIL, 1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one item and returns right after the edge at which it is
    // transferred. Valid stays high on return, so the caller must either
    // send again at once or lower it; no clock may pass in between.
    // Ready is read in the active region right after the edge, which still
    // holds the value it had during the cycle that just ended.
    task automatic send_frame_item(input t_frame_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= it.mode;
        i_sample_0 <= it.smp[0];
        i_sample_1 <= it.smp[1];
        i_sample_2 <= it.smp[2];
        i_sample_3 <= it.smp[3];
        i_sample_4 <= it.smp[4];
        i_sample_5 <= it.smp[5];
        i_sample_6 <= it.smp[6];
        i_sample_7 <= it.smp[7];
        i_sample_8 <= it.smp[8];
        do @(posedge i_clk); while (!o_in_ready);
        predict_frame(it);
        items_sent++;
        if (it.mode == tfe_pkg::MODE_MOT) begin
            mot_frames++;
        end else begin
            att_frames++;
        end
    endtask

    function automatic t_frame_item filled_item(input logic mode, input logic [15:0] v);
        t_frame_item it;
        it.mode = mode;
        for (int i = 0; i < tfe_pkg::NUM_LANES; i++) begin
            it.smp[i] = v;
        end
        return it;
    endfunction

    // Random sample word, weighted toward the edges of the signed range so
    // that the wrap of the most negative value and the sign boundary recur.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            4:       return {8'hFF, 8'($urandom)};
            5:       return {8'h00, 8'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_frame_item random_item();
        t_frame_item it;
        it.mode = $urandom_range(0, 1) ? tfe_pkg::MODE_MOT : tfe_pkg::MODE_ATT;
        for (int i = 0; i < tfe_pkg::NUM_LANES; i++) begin
            it.smp[i] = pick_sample();
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Receiver. A hold-off requested by a test is counted down here and
    // overrides the random stalling while it lasts.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_ready <= 1'b0;
            hold_off_left--;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Checker. Every byte transfer is matched against the oldest pending
    // byte; a transfer with nothing pending is a failure of its own.
    always @(posedge i_clk) begin : frame_byte_checker
        t_frame_byte exp_b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (pending_frame_bytes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("Unexpected byte %h (last %b) with no frame pending.",
                             o_frame_byte, o_last_byte);
                end
            end else begin
                exp_b = pending_frame_bytes.pop_front();
                if (exp_b.frame_byte !== o_frame_byte || exp_b.last_byte !== o_last_byte) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Frame %0d byte %0d: expected %h last %b, got %h last %b.",
                                 frames_checked, byte_in_frame, exp_b.frame_byte,
                                 exp_b.last_byte, o_frame_byte, o_last_byte);
                    end
                end
                if (exp_b.last_byte) begin
                    frames_checked++;
                    byte_in_frame = 0;
                end else begin
                    byte_in_frame++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Directed frames, back to back: both modes with every sample at zero, at
    // the positive and negative extremes, at minus one and at alternating bit
    // patterns; then attitude frames whose rate word is negative and must go out
    // raw while the two unused samples hold other values; then mixed-sign motion frames.
    task automatic test_directed_frames();
        t_frame_item it;
        logic [15:0] fill;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        for (int k = 0; k < 6; k++) begin
            case (k)
                0:       fill = 16'h0000;
                1:       fill = 16'h7FFF;
                2:       fill = 16'h8000;
                3:       fill = 16'hFFFF;
                4:       fill = 16'h5555;
                default: fill = 16'hAAAA;
            endcase
            send_frame_item(filled_item(tfe_pkg::MODE_ATT, fill));
            send_frame_item(filled_item(tfe_pkg::MODE_MOT, fill));
        end

        // The rate word goes out as its raw pattern; the unused samples
        // are set to varied values, extremes among them, and must not show up in the frame.
        it        = filled_item(tfe_pkg::MODE_ATT, 16'h0001);
        it.smp[6] = 16'hFFFF;
        it.smp[7] = 16'h8000;
        it.smp[8] = 16'h7FFF;
        send_frame_item(it);
        it.smp[6] = 16'h8000;
        it.smp[7] = 16'h1234;
        it.smp[8] = 16'hFEDC;
        send_frame_item(it);
        it        = filled_item(tfe_pkg::MODE_ATT, 16'hFFFE);
        it.smp[6] = 16'h8001;
        send_frame_item(it);

        // Motion frames with mixed signs across all nine lanes.
        it = filled_item(tfe_pkg::MODE_MOT, 16'h0000);
        for (int i = 0; i < tfe_pkg::NUM_LANES; i++) begin
            it.smp[i] = (i % 2) ? 16'(-(i + 1)) : 16'(i + 1);
        end
        send_frame_item(it);
        it.smp[8] = 16'h8000;
        it.smp[0] = 16'h7FFF;
        send_frame_item(it);
    endtask

    // Random frames under one idling setting.
    task automatic test_random_frames(input int n_items, input int snd_pct, input int rcv_pct);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        repeat (n_items) begin
            send_frame_item(random_item());
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering items, so the holding register and the serializer fill and
    // input transfers stop until the receiver lets go.
    task automatic test_output_backpressure();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_off_left = HOLD_OFF_LEN;
        repeat (10) begin
            send_frame_item(random_item());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_random_frames(25, 0, 0);
        test_random_frames(25, 74, 0);
        test_random_frames(25, 0, 74);
        test_random_frames(25, 34, 34);
        test_output_backpressure();

        // Stop offering and let the remaining frames drain.
        i_in_valid    <= 1'b0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        while (pending_frame_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d attitude, %0d motion) under four idling mixes and a hold-off.",
                 items_sent, att_frames, mot_frames);
        $display("Checked %0d bytes in %0d frames; %0d mismatches, %0d bytes left over.",
                 bytes_checked, frames_checked, mismatch_count, pending_frame_bytes.size());
        if (mismatch_count == 0 && pending_frame_bytes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/tfe_pkg.sv
sv/tfe_lane.sv
sv/tfe_merge.sv
sv/tfe_serializer.sv
sv/telemetry_frame_encoder_top.sv
sv/tfe_checker.sv
test/telemetry_frame_encoder_top_tb.sv
